/* hdl/tldt_pkg.sv */
// ----------------------------------------------------------------------------
// tldt_pkg
// Shared types and constants for the two-level directory table.
// ----------------------------------------------------------------------------
package tldt_pkg;

  localparam int MAX_DIRS_DEF   = 16;
  localparam int MAX_FILES_DEF  = 16;
  localparam int NAME_BYTES_DEF = 8;

  localparam int KEY_W     = 64;
  localparam int IN_DATA_W = 136;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_CREATE_DIR  = 2'd0,
    OP_CREATE_FILE = 2'd1,
    OP_DELETE_FILE = 2'd2,
    OP_SEARCH_FILE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_DIR_EXISTS   = 3'd1,
    ST_NO_DIR       = 3'd2,
    ST_FILE_EXISTS  = 3'd3,
    ST_FILE_MISSING = 3'd4,
    ST_FULL         = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DSCAN,
    S_FSCAN,
    S_FLAST,
    S_FMOVE,
    S_DONE
  } state_t;

endpackage

/* hdl/tldt_ram.sv */
// ----------------------------------------------------------------------------
// tldt_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tldt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/two_level_directory_table_unit.sv */
// ----------------------------------------------------------------------------
// two_level_directory_table_unit
// Keyed two-level table: directory lookup, then a scan of that directory's
// file list, with create, delete (last entry moves into the hole) and search.
//
//   channel | dir | tdata fields (low bit first)
//   in_     | in  | opcode[1:0], dir_key[65:2], file_key[129:66], zero pad
//   out_    | out | status[2:0], dir_slot[6:3], file_slot[10:7],
//           |     | files_now[15:11]
//
// One item at a time: accept, directory scan, a file scan for file requests,
// a read of the last entry and its move for a delete, then the output
// register. The scans run one entry a cycle through the read port of each
// memory. Of the table state, reset clears the directory count only; counts
// live in the directory memory beside each name. A stalled output holds the
// next result in the done state; a new item is taken once it moves out.
// ----------------------------------------------------------------------------
module two_level_directory_table_unit #(
  parameter int MAX_DIRS   = tldt_pkg::MAX_DIRS_DEF,
  parameter int MAX_FILES  = tldt_pkg::MAX_FILES_DEF,
  parameter int NAME_BYTES = tldt_pkg::NAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode, dir_key, file_key, zero pad
  input  logic [tldt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, dir_slot, file_slot, files_now
  output logic [tldt_pkg::OUT_DATA_W-1:0] out_tdata
);

  import tldt_pkg::*;

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int DA_W   = $clog2(MAX_DIRS);
  localparam int FS_W   = $clog2(MAX_FILES);
  localparam int CW     = $clog2(MAX_FILES + 1);
  localparam int DC_W   = $clog2(MAX_DIRS + 1);
  localparam int FDEPTH = MAX_DIRS * MAX_FILES;
  localparam int FA_W   = $clog2(FDEPTH);
  localparam int IW     = (DC_W > CW) ? DC_W : CW;
  localparam int DE_W   = CW + NAME_W;

  state_t state_r, state_nxt;

  opcode_t           op_r, op_nxt;
  logic [NAME_W-1:0] dkey_r, dkey_nxt;
  logic [NAME_W-1:0] fkey_r, fkey_nxt;
  logic [DC_W-1:0]   dir_count_r, dir_count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     ra_r, ra_nxt;
  logic              rv_r, rv_nxt;
  logic [DA_W-1:0]   dslot_r, dslot_nxt;
  logic [FS_W-1:0]   fslot_r, fslot_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [FA_W-1:0]   base_r, base_nxt;

  status_t           res_status_r, res_status_nxt;
  logic [DA_W-1:0]   res_dslot_r, res_dslot_nxt;
  logic [FS_W-1:0]   res_fslot_r, res_fslot_nxt;
  logic [CW-1:0]     res_fnow_r, res_fnow_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              dir_we;
  logic [DA_W-1:0]   dir_waddr, dir_raddr;
  logic [DE_W-1:0]   dir_wdata, dir_rdata;
  logic              file_we;
  logic [FA_W-1:0]   file_waddr, file_raddr;
  logic [NAME_W-1:0] file_wdata, file_rdata;

  logic              in_acc;
  logic              out_free;
  logic              dmatch, dnone, fmatch, fnone;
  logic [CW-1:0]     rd_cnt;

  tldt_ram #(.WIDTH(DE_W), .DEPTH(MAX_DIRS)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tldt_ram #(.WIDTH(NAME_W), .DEPTH(FDEPTH)) u_file_ram (
    .clk   (clk),
    .we    (file_we),
    .waddr (file_waddr),
    .wdata (file_wdata),
    .raddr (file_raddr),
    .rdata (file_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rd_cnt = dir_rdata[DE_W-1:NAME_W];
  assign dmatch = rv_r && (dir_rdata[NAME_W-1:0] == dkey_r);
  assign dnone  = !rv_r && (idx_r >= IW'(dir_count_r));
  assign fmatch = rv_r && (file_rdata == fkey_r);
  assign fnone  = !rv_r && (idx_r >= IW'(cnt_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DSCAN;
      end
      S_DSCAN: begin
        if (dmatch) begin
          state_nxt = (op_r == OP_CREATE_DIR) ? S_DONE : S_FSCAN;
        end else if (dnone) begin
          state_nxt = S_DONE;
        end
      end
      S_FSCAN: begin
        if (fmatch) begin
          state_nxt = (op_r == OP_DELETE_FILE) ? S_FLAST : S_DONE;
        end else if (fnone) begin
          state_nxt = S_DONE;
        end
      end
      S_FLAST: state_nxt = S_FMOVE;
      S_FMOVE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt         = op_r;
    dkey_nxt       = dkey_r;
    fkey_nxt       = fkey_r;
    dir_count_nxt  = dir_count_r;
    idx_nxt        = idx_r;
    ra_nxt         = ra_r;
    rv_nxt         = 1'b0;
    dslot_nxt      = dslot_r;
    fslot_nxt      = fslot_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    res_status_nxt = res_status_r;
    res_dslot_nxt  = res_dslot_r;
    res_fslot_nxt  = res_fslot_r;
    res_fnow_nxt   = res_fnow_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    dir_we         = 1'b0;
    dir_waddr      = dslot_r;
    dir_wdata      = {cnt_r, dkey_r};
    dir_raddr      = idx_r[DA_W-1:0];
    file_we        = 1'b0;
    file_waddr     = base_r;
    file_wdata     = fkey_r;
    file_raddr     = base_r + FA_W'(idx_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = opcode_t'(in_tdata[1:0]);
          dkey_nxt = in_tdata[2 +: NAME_W];
          fkey_nxt = in_tdata[2 + KEY_W +: NAME_W];
          idx_nxt  = '0;
        end
      end
      S_DSCAN: begin
        if (idx_r < IW'(dir_count_r)) begin
          idx_nxt = idx_r + 1'b1;
          ra_nxt  = idx_r;
          rv_nxt  = 1'b1;
        end
        if (dmatch) begin
          dslot_nxt     = ra_r[DA_W-1:0];
          cnt_nxt       = rd_cnt;
          base_nxt      = FA_W'(ra_r[DA_W-1:0]) * FA_W'(MAX_FILES);
          idx_nxt       = '0;
          rv_nxt        = 1'b0;
          res_dslot_nxt = ra_r[DA_W-1:0];
          res_fslot_nxt = '0;
          res_fnow_nxt  = rd_cnt;
          res_status_nxt = ST_DIR_EXISTS;
        end else if (dnone) begin
          res_dslot_nxt = '0;
          res_fslot_nxt = '0;
          res_fnow_nxt  = '0;
          if (op_r != OP_CREATE_DIR) begin
            res_status_nxt = ST_NO_DIR;
          end else if (dir_count_r == DC_W'(MAX_DIRS)) begin
            res_status_nxt = ST_FULL;
          end else begin
            dir_we         = 1'b1;
            dir_waddr      = dir_count_r[DA_W-1:0];
            dir_wdata      = {{CW{1'b0}}, dkey_r};
            dir_count_nxt  = dir_count_r + 1'b1;
            res_dslot_nxt  = dir_count_r[DA_W-1:0];
            res_status_nxt = ST_OK;
          end
        end
      end
      S_FSCAN: begin
        if (idx_r < IW'(cnt_r)) begin
          idx_nxt = idx_r + 1'b1;
          ra_nxt  = idx_r;
          rv_nxt  = 1'b1;
        end
        res_dslot_nxt = dslot_r;
        res_fnow_nxt  = cnt_r;
        if (fmatch) begin
          fslot_nxt     = ra_r[FS_W-1:0];
          res_fslot_nxt = ra_r[FS_W-1:0];
          rv_nxt        = 1'b0;
          res_status_nxt = (op_r == OP_CREATE_FILE) ? ST_FILE_EXISTS : ST_OK;
        end else if (fnone) begin
          res_fslot_nxt = '0;
          if (op_r != OP_CREATE_FILE) begin
            res_status_nxt = ST_FILE_MISSING;
          end else if (cnt_r == CW'(MAX_FILES)) begin
            res_status_nxt = ST_FULL;
          end else begin
            file_we        = 1'b1;
            file_waddr     = base_r + FA_W'(cnt_r);
            file_wdata     = fkey_r;
            dir_we         = 1'b1;
            dir_wdata      = {cnt_r + 1'b1, dkey_r};
            res_fslot_nxt  = cnt_r[FS_W-1:0];
            res_fnow_nxt   = cnt_r + 1'b1;
            res_status_nxt = ST_OK;
          end
        end
      end
      S_FLAST: begin
        file_raddr = base_r + FA_W'(cnt_r - 1'b1);
      end
      S_FMOVE: begin
        file_we        = 1'b1;
        file_waddr     = base_r + FA_W'(fslot_r);
        file_wdata     = file_rdata;
        dir_we         = 1'b1;
        dir_wdata      = {cnt_r - 1'b1, dkey_r};
        res_fnow_nxt   = cnt_r - 1'b1;
        res_status_nxt = ST_OK;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'(res_fnow_r), 4'(res_fslot_r), 4'(res_dslot_r),
                           res_status_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_count_r <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_count_r <= dir_count_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    dkey_r       <= dkey_nxt;
    fkey_r       <= fkey_nxt;
    idx_r        <= idx_nxt;
    ra_r         <= ra_nxt;
    dslot_r      <= dslot_nxt;
    fslot_r      <= fslot_nxt;
    cnt_r        <= cnt_nxt;
    base_r       <= base_nxt;
    res_status_r <= res_status_nxt;
    res_dslot_r  <= res_dslot_nxt;
    res_fslot_r  <= res_fslot_nxt;
    res_fnow_r   <= res_fnow_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

/* verif/tldt_checker.sv */
// ----------------------------------------------------------------------------
// tldt_checker
// Watches both item channels of the directory table. Keeps its own copy of
// the directories and file lists, predicts one status item per request and
// compares every result item field by field, oldest prediction first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tldt_checker #(
  parameter int MAX_DIRS   = tldt_pkg::MAX_DIRS_DEF,
  parameter int MAX_FILES  = tldt_pkg::MAX_FILES_DEF,
  parameter int NAME_BYTES = tldt_pkg::NAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // opcode, dir_key, file_key, zero pad
  input  logic [tldt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // status, dir_slot, file_slot, files_now
  input  logic [tldt_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results_checked,
  output logic [5:0]                      status_seen
);
  import tldt_pkg::*;

  localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES);
  localparam int REPORT_MAX = 10;

  typedef struct {
    status_t    status;
    logic [3:0] dir_slot;
    logic [3:0] file_slot;
    logic [4:0] files_now;
  } dir_reply_t;

  logic [KEY_W-1:0] dir_name_mem [MAX_DIRS];
  logic [KEY_W-1:0] file_name_mem [MAX_DIRS][MAX_FILES];
  int               dir_files [MAX_DIRS];
  int               dir_total;
  dir_reply_t       awaited_replies [$];

  function automatic dir_reply_t apply_request(input opcode_t op,
                                               input logic [KEY_W-1:0] dkey_in,
                                               input logic [KEY_W-1:0] fkey_in);
    dir_reply_t       r;
    logic [KEY_W-1:0] dkey;
    logic [KEY_W-1:0] fkey;
    int               d;
    int               f;
    int               i;
    int               last;
    dkey = dkey_in & NAME_MASK;
    fkey = fkey_in & NAME_MASK;
    r.status    = ST_OK;
    r.dir_slot  = '0;
    r.file_slot = '0;
    r.files_now = '0;
    d = MAX_DIRS;
    for (i = dir_total - 1; i >= 0; i--) begin
      if (dir_name_mem[i] == dkey) d = i;
    end
    if (op == OP_CREATE_DIR) begin
      if (d < MAX_DIRS) begin
        r.status    = ST_DIR_EXISTS;
        r.dir_slot  = 4'(d);
        r.files_now = 5'(dir_files[d]);
      end else if (dir_total >= MAX_DIRS) begin
        r.status = ST_FULL;
      end else begin
        dir_name_mem[dir_total] = dkey;
        dir_files[dir_total]    = 0;
        r.dir_slot              = 4'(dir_total);
        dir_total++;
      end
    end else if (d == MAX_DIRS) begin
      r.status = ST_NO_DIR;
    end else begin
      f = MAX_FILES;
      for (i = dir_files[d] - 1; i >= 0; i--) begin
        if (file_name_mem[d][i] == fkey) f = i;
      end
      r.dir_slot = 4'(d);
      if (op == OP_CREATE_FILE) begin
        if (f < MAX_FILES) begin
          r.status    = ST_FILE_EXISTS;
          r.file_slot = 4'(f);
        end else if (dir_files[d] >= MAX_FILES) begin
          r.status = ST_FULL;
        end else begin
          file_name_mem[d][dir_files[d]] = fkey;
          r.file_slot = 4'(dir_files[d]);
          dir_files[d]++;
        end
      end else if (f == MAX_FILES) begin
        r.status = ST_FILE_MISSING;
      end else begin
        r.file_slot = 4'(f);
        if (op == OP_DELETE_FILE) begin
          // last entry fills the hole
          last = dir_files[d] - 1;
          file_name_mem[d][f] = file_name_mem[d][last];
          dir_files[d] = last;
        end
      end
      r.files_now = 5'(dir_files[d]);
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    dir_reply_t got;
    dir_reply_t want;
    int         i;
    if (!rst_n) begin
      dir_total = 0;
      for (i = 0; i < MAX_DIRS; i++) dir_files[i] = 0;
      awaited_replies.delete();
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      status_seen     = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status    = status_t'(out_tdata[2:0]);
        got.dir_slot  = out_tdata[6:3];
        got.file_slot = out_tdata[10:7];
        got.files_now = out_tdata[15:11];
        results_checked++;
        if (out_tdata[2:0] < 6) status_seen[out_tdata[2:0]] = 1'b1;
        if (awaited_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t tldt_checker: unexpected result item, data %h", $realtime,
                     out_tdata);
        end else begin
          want = awaited_replies.pop_front();
          if (got.status != want.status || got.dir_slot != want.dir_slot ||
              got.file_slot != want.file_slot || got.files_now != want.files_now) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t tldt_checker: mismatch,", $realtime,
                       " exp status %0d dir %0d file %0d count %0d,", want.status,
                       want.dir_slot, want.file_slot, want.files_now,
                       " got status %0d dir %0d file %0d count %0d", got.status,
                       got.dir_slot, got.file_slot, got.files_now);
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_replies.push_back(apply_request(opcode_t'(in_tdata[1:0]), in_tdata[65:2],
                                                in_tdata[129:66]));
      outstanding = awaited_replies.size();
    end
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the two-level directory table: a directed pass over
// the duplicate and missing cases, then random directory growth toward the
// full cases, mixed lookups and noise, random idling on both sides, one long
// output stall and three full drains. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tldt_pkg::*;

  localparam int REQ_TOTAL  = 650;
  localparam int CALM_TAIL  = 80;
  localparam int HOLD_AT    = 260;
  localparam int DRAIN_AT   = 420;
  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int N_DKEYS    = 20;
  localparam int N_FKEYS    = 24;
  localparam int HOT_DIRS   = 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int         fail_count;
  int         outstanding;
  int         results_checked;
  logic [5:0] status_seen;

  int               sent;
  int               quiet_cycles;
  bit               calm;
  bit               long_hold_req;
  bit               long_hold_done;
  logic [KEY_W-1:0] dir_keys [N_DKEYS];
  logic [KEY_W-1:0] file_keys [N_FKEYS];

  always #5 clk = ~clk;

  two_level_directory_table_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tldt_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .status_seen     (status_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off
  initial begin : sink
    int n;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pick_dir();
    if ($urandom_range(0, 9) < 7) return dir_keys[$urandom_range(0, HOT_DIRS - 1)];
    return dir_keys[$urandom_range(0, N_DKEYS - 1)];
  endfunction

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  task automatic send_request(input opcode_t op, input logic [KEY_W-1:0] dkey,
                              input logic [KEY_W-1:0] fkey);
    int gap;
    calm = (sent >= REQ_TOTAL - CALM_TAIL);
    if (sent == HOLD_AT) long_hold_req = 1'b1;
    if (sent == DRAIN_AT) begin
      drain_results();
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - 2 - 2 * KEY_W){1'b0}}, fkey, dkey, op};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  initial begin : stim
    int      i;
    int      k;
    int      n;
    int      base;
    int      pick;
    int      r;
    opcode_t op;
    logic [KEY_W-1:0] dk;
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    sent           = 0;
    calm           = 1'b0;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    for (i = 0; i < N_DKEYS; i++) dir_keys[i] = rand_key();
    for (i = 0; i < N_FKEYS; i++) file_keys[i] = rand_key();
    dir_keys[0]  = '0;
    dir_keys[1]  = '1;
    file_keys[0] = '0;
    file_keys[1] = '1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: duplicates, missing directory and file, delete with move
    send_request(OP_CREATE_DIR,  dir_keys[0], '0);
    send_request(OP_CREATE_DIR,  dir_keys[1], '1);
    send_request(OP_CREATE_DIR,  dir_keys[0], rand_key());
    send_request(OP_CREATE_FILE, dir_keys[2], file_keys[0]);
    send_request(OP_DELETE_FILE, dir_keys[2], file_keys[1]);
    send_request(OP_SEARCH_FILE, dir_keys[2], file_keys[2]);
    send_request(OP_SEARCH_FILE, dir_keys[0], file_keys[0]);
    send_request(OP_DELETE_FILE, dir_keys[0], file_keys[0]);
    send_request(OP_CREATE_FILE, dir_keys[0], file_keys[0]);
    send_request(OP_CREATE_FILE, dir_keys[0], file_keys[1]);
    send_request(OP_CREATE_FILE, dir_keys[0], file_keys[2]);
    send_request(OP_CREATE_FILE, dir_keys[0], file_keys[1]);
    send_request(OP_SEARCH_FILE, dir_keys[0], file_keys[2]);
    send_request(OP_DELETE_FILE, dir_keys[0], file_keys[0]);
    send_request(OP_SEARCH_FILE, dir_keys[0], file_keys[2]);
    send_request(OP_DELETE_FILE, dir_keys[0], file_keys[2]);
    send_request(OP_DELETE_FILE, dir_keys[0], file_keys[1]);
    send_request(OP_SEARCH_FILE, dir_keys[0], file_keys[1]);
    send_request(OP_CREATE_FILE, dir_keys[1], file_keys[3]);
    send_request(OP_CREATE_DIR,  dir_keys[1], rand_key());
    send_request(OP_SEARCH_FILE, dir_keys[1], file_keys[3]);
    drain_results();

    // random: directory growth, mixed traffic on known names, noise
    while (sent < REQ_TOTAL) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        dk = pick_dir();
        send_request(OP_CREATE_DIR, dk, rand_key());
        base = $urandom_range(0, N_FKEYS - 1);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          send_request(OP_CREATE_FILE, dk, file_keys[(base + k) % N_FKEYS]);
      end else if (pick < 8) begin
        for (k = 0; k < 8; k++) begin
          r = $urandom_range(0, 9);
          if (r == 0) op = OP_CREATE_DIR;
          else if (r < 5) op = OP_CREATE_FILE;
          else if (r < 7) op = OP_DELETE_FILE;
          else op = OP_SEARCH_FILE;
          send_request(op, pick_dir(), file_keys[$urandom_range(0, N_FKEYS - 1)]);
        end
      end else begin
        for (k = 0; k < 4; k++) begin
          op = opcode_t'($urandom_range(0, 3));
          dk = ($urandom_range(0, 3) == 0) ? rand_key() : pick_dir();
          send_request(op, dk, ($urandom_range(0, 1) == 0) ? rand_key() :
                                file_keys[$urandom_range(0, N_FKEYS - 1)]);
        end
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("run covered %0d requests and %0d checked results, with a long output stall",
             sent, results_checked);
    $display("and a full drain pause; status codes observed (bit per code): %b",
             status_seen);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
